// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on a rising edge, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// consequent holds at the edge after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hbbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// hbbsm_pkg
// Types, codes and constants of the heater bang-bang safety monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbbsm_pkg;

    parameter int TEMP_W   = 13;
    parameter int TGT_W    = 12;
    parameter int CALC_W   = 15;
    parameter int TIMER_W  = 10;
    parameter int CNT_W    = 8;
    parameter int PWM_W    = 8;
    parameter int APB_AW   = 5;
    parameter int APB_DW   = 32;

    parameter int PWM_MAX          = 255;
    parameter int RUNAWAY_BAND     = 16;
    parameter int RUNAWAY_TICKS    = 40;
    parameter int LOW_SAMPLE_LIMIT = 16;
    parameter int TARGET_MARGIN    = 10;
    parameter int GOAL_MAX         = 4095;

    parameter int RST_TARGET   = 0;
    parameter int RST_MAX      = 1100;
    parameter int RST_MIN      = 20;
    parameter int RST_HYST     = 8;
    parameter int RST_INTERVAL = 1;
    parameter int RST_PERIOD   = 20;
    parameter int RST_INCREASE = 8;
    parameter int RST_MODE     = 1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_ARM   = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        PH_INACTIVE = 2'd0,
        PH_FIRST    = 2'd1,
        PH_STABLE   = 2'd2,
        PH_RUNAWAY  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_MAX     = 3'd1,
        CAUSE_MIN     = 3'd2,
        CAUSE_RUNAWAY = 3'd3,
        CAUSE_HEAT    = 3'd4
    } cause_t;

    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_MAX      = 3'd1,
        REG_MIN      = 3'd2,
        REG_HYST     = 3'd3,
        REG_INTERVAL = 3'd4,
        REG_PERIOD   = 3'd5,
        REG_INCREASE = 3'd6,
        REG_MODE     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [TGT_W-1:0]   set_point;
        logic [TGT_W-1:0]   max_temp;
        logic [TEMP_W-1:0]  min_temp;
        logic [7:0]         hysteresis;
        logic [TIMER_W-1:0] check_interval;
        logic [TIMER_W-1:0] rise_window;
        logic [7:0]         rise_step;
        logic [1:0]         mode_flags;
    } cfg_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm;
        logic             active;
        logic             fault;
        cause_t           cause;
        phase_t           phase;
    } res_t;

endpackage

// ===== hdl/hbbsm_regs.sv =====
// ----------------------------------------------------------------------------
// hbbsm_regs
// APB configuration register file of the safety monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbbsm_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hbbsm_pkg::APB_AW-1:0] paddr,
    input  logic [hbbsm_pkg::APB_DW-1:0] pwdata,
    output logic [hbbsm_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output hbbsm_pkg::cfg_t              cfg
);
    import hbbsm_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_TARGET:   cfg_next.set_point      = pwdata[TGT_W-1:0];
                REG_MAX:      cfg_next.max_temp       = pwdata[TGT_W-1:0];
                REG_MIN:      cfg_next.min_temp       = pwdata[TEMP_W-1:0];
                REG_HYST:     cfg_next.hysteresis     = pwdata[7:0];
                REG_INTERVAL: cfg_next.check_interval = pwdata[TIMER_W-1:0];
                REG_PERIOD:   cfg_next.rise_window    = pwdata[TIMER_W-1:0];
                REG_INCREASE: cfg_next.rise_step      = pwdata[7:0];
                REG_MODE:     cfg_next.mode_flags     = pwdata[1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_point      <= TGT_W'(RST_TARGET);
            cfg_reg.max_temp       <= TGT_W'(RST_MAX);
            cfg_reg.min_temp       <= TEMP_W'(RST_MIN);
            cfg_reg.hysteresis     <= 8'(RST_HYST);
            cfg_reg.check_interval <= TIMER_W'(RST_INTERVAL);
            cfg_reg.rise_window    <= TIMER_W'(RST_PERIOD);
            cfg_reg.rise_step      <= 8'(RST_INCREASE);
            cfg_reg.mode_flags     <= 2'(RST_MODE);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_TARGET:   prdata = APB_DW'(cfg_reg.set_point);
            REG_MAX:      prdata = APB_DW'(cfg_reg.max_temp);
            REG_MIN:      prdata = APB_DW'(cfg_reg.min_temp);
            REG_HYST:     prdata = APB_DW'(cfg_reg.hysteresis);
            REG_INTERVAL: prdata = APB_DW'(cfg_reg.check_interval);
            REG_PERIOD:   prdata = APB_DW'(cfg_reg.rise_window);
            REG_INCREASE: prdata = APB_DW'(cfg_reg.rise_step);
            REG_MODE:     prdata = APB_DW'(cfg_reg.mode_flags);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== hdl/hbbsm_core.sv =====
// ----------------------------------------------------------------------------
// hbbsm_core
// Supervisor state and the single-pass update for one tick, arm or clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbbsm_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [1:0]                   func,
    input  logic [hbbsm_pkg::TEMP_W-1:0] temperature,
    input  hbbsm_pkg::cfg_t              cfg,
    output hbbsm_pkg::res_t              res_next
);
    import hbbsm_pkg::*;

    localparam logic signed [CALC_W-1:0] BAND_W   = CALC_W'(RUNAWAY_BAND);
    localparam logic signed [CALC_W-1:0] MARGIN_W = CALC_W'(TARGET_MARGIN);
    localparam logic signed [CALC_W-1:0] GOAL_W   = CALC_W'(GOAL_MAX);
    localparam logic [TIMER_W-1:0]       TMR_SAT  = {TIMER_W{1'b1}};
    localparam logic [CNT_W-1:0]         CNT_SAT  = {CNT_W{1'b1}};
    localparam logic [TIMER_W-1:0]       TICKS_C  = TIMER_W'(RUNAWAY_TICKS);
    localparam logic [CNT_W-1:0]         LOW_LIM  = CNT_W'(LOW_SAMPLE_LIMIT);
    localparam logic [PWM_W-1:0]         PWM_FULL = PWM_W'(PWM_MAX);

    phase_t              phase_reg,  phase_next;
    logic [TGT_W-1:0]    eff_reg,    eff_next;
    logic                act_reg,    act_next;
    logic                fault_reg,  fault_next;
    cause_t              cause_reg,  cause_next;
    logic [CNT_W-1:0]    low_reg,    low_next;
    logic [TIMER_W-1:0]  rt_reg,     rt_next;
    logic [TIMER_W-1:0]  ct_reg,     ct_next;
    logic                watch_reg,  watch_next;
    logic [TEMP_W-1:0]   goal_reg,   goal_next;
    logic [TIMER_W-1:0]  wt_reg,     wt_next;
    logic [PWM_W-1:0]    duty_reg,   duty_next;

    logic                    prot;
    logic                    cooler;
    logic                    fault_hit;
    cause_t                  cause_hit;
    logic signed [CALC_W-1:0] t_w, tgt_w, max_w, min_w, hys_w, inc_w, goal_w;
    logic signed [CALC_W-1:0] guard_w, lim_w, req_w, arm_w, sum_w;
    logic [TGT_W-1:0]         arm_tgt;
    logic [TEMP_W-1:0]        goal_sat;

    assign prot    = cfg.mode_flags[0];
    assign cooler  = cfg.mode_flags[1];
    assign t_w     = {{(CALC_W-TEMP_W){temperature[TEMP_W-1]}}, temperature};
    assign tgt_w   = {{(CALC_W-TGT_W){1'b0}}, eff_reg};
    assign max_w   = {{(CALC_W-TGT_W){1'b0}}, cfg.max_temp};
    assign min_w   = {{(CALC_W-TEMP_W){cfg.min_temp[TEMP_W-1]}}, cfg.min_temp};
    assign hys_w   = {{(CALC_W-8){1'b0}}, cfg.hysteresis};
    assign inc_w   = {{(CALC_W-8){1'b0}}, cfg.rise_step};
    assign goal_w  = {{(CALC_W-TEMP_W){goal_reg[TEMP_W-1]}}, goal_reg};
    assign guard_w = inc_w + hys_w + CALC_W'(1);
    assign sum_w   = t_w + inc_w;
    assign goal_sat = (sum_w > GOAL_W) ? TEMP_W'(GOAL_MAX) : sum_w[TEMP_W-1:0];

    // clamp the requested target to the limit band
    assign lim_w   = max_w - MARGIN_W;
    assign req_w   = {{(CALC_W-TGT_W){1'b0}}, cfg.set_point};
    always_comb begin
        arm_w = (req_w > lim_w) ? lim_w : req_w;
        if (arm_w < 0) begin
            arm_w = '0;
        end
    end
    assign arm_tgt = arm_w[TGT_W-1:0];

    always_comb begin
        phase_next = phase_reg;
        eff_next   = eff_reg;
        act_next   = act_reg;
        fault_next = fault_reg;
        cause_next = cause_reg;
        low_next   = low_reg;
        rt_next    = rt_reg;
        ct_next    = ct_reg;
        watch_next = watch_reg;
        goal_next  = goal_reg;
        wt_next    = wt_reg;
        duty_next  = duty_reg;
        fault_hit  = 1'b0;
        cause_hit  = CAUSE_NONE;

        case (func_t'(func))
            FUNC_TICK: begin
                if (act_reg && t_w > max_w) begin
                    fault_hit = 1'b1;
                    cause_hit = CAUSE_MAX;
                end
                if (act_reg && !fault_hit && t_w < min_w) begin
                    low_next = (low_reg == CNT_SAT) ? low_reg : low_reg + CNT_W'(1);
                    if (low_next >= LOW_LIM) begin
                        if (!fault_hit) begin
                            cause_hit = CAUSE_MIN;
                        end
                        fault_hit = 1'b1;
                    end
                end else begin
                    low_next = '0;
                end

                if (prot) begin
                    if (phase_next == PH_FIRST && t_w >= tgt_w) begin
                        phase_next = PH_STABLE;
                    end
                    if (phase_next == PH_STABLE) begin
                        if (t_w >= tgt_w - BAND_W) begin
                            rt_next = '0;
                        end else begin
                            rt_next = (rt_reg == TMR_SAT) ? rt_reg : rt_reg + TIMER_W'(1);
                            if (rt_next >= TICKS_C) begin
                                phase_next = PH_RUNAWAY;
                            end
                        end
                    end
                    if (phase_next == PH_RUNAWAY) begin
                        if (!fault_hit) begin
                            cause_hit = CAUSE_RUNAWAY;
                        end
                        fault_hit = 1'b1;
                    end
                end

                if (act_reg && !fault_hit) begin
                    ct_next = (ct_reg == TMR_SAT) ? ct_reg : ct_reg + TIMER_W'(1);
                    if (ct_next >= cfg.check_interval) begin
                        ct_next = '0;
                        if (cooler) begin
                            if (t_w <= tgt_w - hys_w) begin
                                duty_next = '0;
                            end else if (t_w >= tgt_w + hys_w) begin
                                duty_next = PWM_FULL;
                            end
                        end else begin
                            if (t_w >= tgt_w + hys_w) begin
                                duty_next = '0;
                            end else if (t_w <= tgt_w - hys_w) begin
                                duty_next = PWM_FULL;
                            end
                        end
                    end
                end

                if (prot && watch_reg && !fault_hit) begin
                    wt_next = (wt_reg == TMR_SAT) ? wt_reg : wt_reg + TIMER_W'(1);
                    if (wt_next >= cfg.rise_window) begin
                        if (t_w < goal_w) begin
                            fault_hit = 1'b1;
                            cause_hit = CAUSE_HEAT;
                        end else if (act_reg && t_w < tgt_w - guard_w) begin
                            goal_next  = goal_sat;
                            wt_next    = '0;
                            watch_next = 1'b1;
                        end else begin
                            watch_next = 1'b0;
                        end
                    end
                end

                if (fault_hit) begin
                    fault_next = 1'b1;
                    if (!fault_reg) begin
                        cause_next = cause_hit;
                    end
                    act_next   = 1'b0;
                    duty_next  = '0;
                    watch_next = 1'b0;
                end
            end
            FUNC_ARM: begin
                if (cfg.set_point == '0) begin
                    act_next   = 1'b0;
                    duty_next  = '0;
                    eff_next   = '0;
                    phase_next = PH_INACTIVE;
                    watch_next = 1'b0;
                end else if (!fault_reg) begin
                    act_next   = 1'b1;
                    eff_next   = arm_tgt;
                    phase_next = (arm_tgt != '0) ? PH_FIRST : PH_INACTIVE;
                    rt_next    = '0;
                    if (prot) begin
                        if (t_w < arm_w - guard_w) begin
                            goal_next  = goal_sat;
                            wt_next    = '0;
                            watch_next = 1'b1;
                        end else begin
                            watch_next = 1'b0;
                        end
                    end
                end
            end
            FUNC_CLEAR: begin
                phase_next = PH_INACTIVE;
                eff_next   = '0;
                act_next   = 1'b0;
                fault_next = 1'b0;
                cause_next = CAUSE_NONE;
                low_next   = '0;
                rt_next    = '0;
                ct_next    = '0;
                watch_next = 1'b0;
                goal_next  = '0;
                wt_next    = '0;
                duty_next  = '0;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (!act_next) begin
            duty_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INACTIVE;
            eff_reg   <= '0;
            act_reg   <= 1'b0;
            fault_reg <= 1'b0;
            cause_reg <= CAUSE_NONE;
            low_reg   <= '0;
            rt_reg    <= '0;
            ct_reg    <= '0;
            watch_reg <= 1'b0;
            goal_reg  <= '0;
            wt_reg    <= '0;
            duty_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            eff_reg   <= eff_next;
            act_reg   <= act_next;
            fault_reg <= fault_next;
            cause_reg <= cause_next;
            low_reg   <= low_next;
            rt_reg    <= rt_next;
            ct_reg    <= ct_next;
            watch_reg <= watch_next;
            goal_reg  <= goal_next;
            wt_reg    <= wt_next;
            duty_reg  <= duty_next;
        end
    end

    assign res_next.pwm    = duty_next;
    assign res_next.active = act_next;
    assign res_next.fault  = fault_next;
    assign res_next.cause  = cause_next;
    assign res_next.phase  = phase_next;

endmodule

// ===== hdl/heater_bang_bang_safety_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// heater_bang_bang_safety_monitor_unit
// Heater/cooler supervisor: bang-bang duty, over/under temperature, runaway
// and heating watch protection with a latched fault.
//
//   channel  direction  ports
//   s_       in         s_valid s_ready s_func s_temperature
//   m_       out        m_valid m_ready m_pwm_out m_active m_fault
//                       m_fault_cause m_runaway_phase
//   apb      in/out     psel penable pwrite paddr pwdata prdata pready
//
// One beat per cycle sustained while m_ready stays high; an accepted beat passes
// the input register, then the single-pass update into the result register.
// Reset clears the supervisor state and loads the register defaults.
// A stalled result holds the result register; the input register still takes
// a beat while the result register is full and waits behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heater_bang_bang_safety_monitor_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [hbbsm_pkg::TEMP_W-1:0] s_temperature,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hbbsm_pkg::PWM_W-1:0]  m_pwm_out,
    output logic                         m_active,
    output logic                         m_fault,
    output logic [2:0]                   m_fault_cause,
    output logic [1:0]                   m_runaway_phase,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hbbsm_pkg::APB_AW-1:0] paddr,
    input  logic [hbbsm_pkg::APB_DW-1:0] pwdata,
    output logic [hbbsm_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import hbbsm_pkg::*;

    cfg_t              cfg;
    res_t              res_next;
    res_t              out_reg;
    logic              out_valid_reg;
    logic              in_valid_reg;
    logic [1:0]        in_func_reg;
    logic [TEMP_W-1:0] in_temp_reg;
    logic              out_free;
    logic              advance;
    logic              in_take;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    hbbsm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbbsm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .func        (in_func_reg),
        .temperature (in_temp_reg),
        .cfg         (cfg),
        .res_next    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_func_reg <= s_func;
            in_temp_reg <= s_temperature;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pwm_out       = out_reg.pwm;
    assign m_active        = out_reg.active;
    assign m_fault         = out_reg.fault;
    assign m_fault_cause   = out_reg.cause;
    assign m_runaway_phase = out_reg.phase;

    `ASSERT_ALWAYS(a_idle_duty_zero, aclk, aresetn,
        !out_valid_reg || out_reg.active || out_reg.pwm == '0, "duty while inactive")
    `ASSERT_ALWAYS(a_fault_cause_match, aclk, aresetn,
        !out_valid_reg || ((out_reg.cause != CAUSE_NONE) == out_reg.fault),
        "fault cause does not match fault flag")
    `ASSERT_ALWAYS(a_fault_stops_drive, aclk, aresetn,
        !out_valid_reg || !out_reg.fault || !out_reg.active, "active while faulted")
    `ASSERT_ALWAYS(a_runaway_faults, aclk, aresetn,
        !out_valid_reg || out_reg.phase != PH_RUNAWAY || out_reg.fault,
        "runaway phase without fault")
    `ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !out_free, in_valid_reg,
        "input beat dropped while stalled")

endmodule

// ===== tb/sv/heater_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_result_checker
// Watches the register port and both beat channels of the heater supervisor.
// Keeps its own copy of the registers and of the supervisor state, computes
// the status beat that each accepted input beat must produce, and compares
// every result beat field by field against the oldest expected status.
// ----------------------------------------------------------------------------

module heater_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [12:0] s_temperature,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_pwm_out,
    input  logic        m_active,
    input  logic        m_fault,
    input  logic [2:0]  m_fault_cause,
    input  logic [1:0]  m_runaway_phase,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);

    import hbbsm_pkg::*;

    localparam logic [7:0] DUTY_FULL     = 8'd255;
    localparam int         RUN_BAND      = 16;
    localparam int         RUNAWAY_LIMIT = 40;
    localparam int         LOW_LIMIT     = 16;
    localparam int         MARGIN        = 10;
    localparam int         GOAL_CEIL     = 4095;

    logic [11:0]        cfg_target;
    logic [11:0]        cfg_max;
    logic signed [12:0] cfg_min;
    logic [7:0]         cfg_hyst;
    logic [9:0]         cfg_interval;
    logic [9:0]         cfg_period;
    logic [7:0]         cfg_rise;
    logic [1:0]         cfg_mode;

    phase_t             st_phase;
    logic [11:0]        tgt_q;
    logic               ctl_active;
    logic               fault_q;
    cause_t             cause_q;
    logic [7:0]         low_cnt;
    logic [9:0]         runaway_cnt;
    logic [9:0]         check_cnt;
    logic               watch_on;
    logic signed [12:0] watch_goal;
    logic [9:0]         watch_cnt;
    logic [7:0]         duty_q;

    res_t expected_status[$];
    res_t want;
    int   bad_fields = 0;

    function automatic void clear_supervisor();
        st_phase    = PH_INACTIVE;
        tgt_q       = '0;
        ctl_active  = 1'b0;
        fault_q     = 1'b0;
        cause_q     = CAUSE_NONE;
        low_cnt     = '0;
        runaway_cnt = '0;
        check_cnt   = '0;
        watch_on    = 1'b0;
        watch_goal  = '0;
        watch_cnt   = '0;
        duty_q      = '0;
    endfunction

    function automatic void latch_fault(cause_t why);
        if (!fault_q) begin
            cause_q = why;
        end
        fault_q    = 1'b1;
        ctl_active = 1'b0;
        duty_q     = '0;
        watch_on   = 1'b0;
    endfunction

    function automatic void restart_watch(int t);
        int g;
        if (cfg_mode[0]) begin
            if (ctl_active && t < int'(tgt_q) - (int'(cfg_rise) + int'(cfg_hyst) + 1)) begin
                g = t + int'(cfg_rise);
                if (g > GOAL_CEIL) begin
                    g = GOAL_CEIL;
                end
                watch_goal = g[12:0];
                watch_cnt  = '0;
                watch_on   = 1'b1;
            end else begin
                watch_on = 1'b0;
            end
        end
    endfunction

    function automatic void predict_beat(logic [1:0] op, int t);
        logic prot;
        int   tgt;
        int   hy;
        int   req;
        int   lim;
        res_t r;
        prot = cfg_mode[0];
        tgt  = int'(tgt_q);
        hy   = int'(cfg_hyst);
        case (op)
            FUNC_TICK: begin
                if (ctl_active && t > int'(cfg_max)) begin
                    latch_fault(CAUSE_MAX);
                end
                if (ctl_active && t < int'(cfg_min)) begin
                    if (low_cnt != 8'hFF) begin
                        low_cnt++;
                    end
                    if (low_cnt >= LOW_LIMIT) begin
                        latch_fault(CAUSE_MIN);
                    end
                end else begin
                    low_cnt = '0;
                end
                if (prot) begin
                    if (st_phase == PH_FIRST && t >= tgt) begin
                        st_phase = PH_STABLE;
                    end
                    if (st_phase == PH_STABLE) begin
                        if (t >= tgt - RUN_BAND) begin
                            runaway_cnt = '0;
                        end else begin
                            if (runaway_cnt != 10'h3FF) begin
                                runaway_cnt++;
                            end
                            if (runaway_cnt >= RUNAWAY_LIMIT) begin
                                st_phase = PH_RUNAWAY;
                            end
                        end
                    end
                    if (st_phase == PH_RUNAWAY) begin
                        latch_fault(CAUSE_RUNAWAY);
                    end
                end
                if (ctl_active) begin
                    if (check_cnt != 10'h3FF) begin
                        check_cnt++;
                    end
                    if (check_cnt >= cfg_interval) begin
                        check_cnt = '0;
                        if (cfg_mode[1]) begin
                            if (t <= tgt - hy) begin
                                duty_q = '0;
                            end else if (t >= tgt + hy) begin
                                duty_q = DUTY_FULL;
                            end
                        end else begin
                            if (t >= tgt + hy) begin
                                duty_q = '0;
                            end else if (t <= tgt - hy) begin
                                duty_q = DUTY_FULL;
                            end
                        end
                    end
                end
                if (prot && watch_on) begin
                    if (watch_cnt != 10'h3FF) begin
                        watch_cnt++;
                    end
                    if (watch_cnt >= cfg_period) begin
                        if (t < int'(watch_goal)) begin
                            latch_fault(CAUSE_HEAT);
                        end else begin
                            restart_watch(t);
                        end
                    end
                end
            end
            FUNC_ARM: begin
                req = int'(cfg_target);
                lim = int'(cfg_max) - MARGIN;
                if (req == 0) begin
                    ctl_active = 1'b0;
                    duty_q     = '0;
                    tgt_q      = '0;
                    st_phase   = PH_INACTIVE;
                    watch_on   = 1'b0;
                end else if (!fault_q) begin
                    if (req > lim) begin
                        req = lim;
                    end
                    if (req < 0) begin
                        req = 0;
                    end
                    ctl_active  = 1'b1;
                    tgt_q       = req[11:0];
                    st_phase    = (req > 0) ? PH_FIRST : PH_INACTIVE;
                    runaway_cnt = '0;
                    restart_watch(t);
                end
            end
            FUNC_CLEAR: begin
                clear_supervisor();
            end
            default: begin
            end
        endcase
        if (!ctl_active) begin
            duty_q = '0;
        end
        r.pwm    = duty_q;
        r.active = ctl_active;
        r.fault  = fault_q;
        r.cause  = cause_q;
        r.phase  = st_phase;
        expected_status.push_back(r);
    endfunction

    function automatic void check_field(string fname, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d actual %0d", $time, fname, exp_val, act_val);
            bad_fields++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_target   = 12'd0;
            cfg_max      = 12'd1100;
            cfg_min      = 13'sd20;
            cfg_hyst     = 8'd8;
            cfg_interval = 10'd1;
            cfg_period   = 10'd20;
            cfg_rise     = 8'd8;
            cfg_mode     = 2'b01;
            clear_supervisor();
            expected_status.delete();
            bad_fields = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_TARGET:   cfg_target   = pwdata[11:0];
                    REG_MAX:      cfg_max      = pwdata[11:0];
                    REG_MIN:      cfg_min      = pwdata[12:0];
                    REG_HYST:     cfg_hyst     = pwdata[7:0];
                    REG_INTERVAL: cfg_interval = pwdata[9:0];
                    REG_PERIOD:   cfg_period   = pwdata[9:0];
                    REG_INCREASE: cfg_rise     = pwdata[7:0];
                    REG_MODE:     cfg_mode     = pwdata[1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: status beat expected none actual pwm %0d active %0d",
                             $time, m_pwm_out, m_active);
                    $display("%0t:   fault %0d cause %0d phase %0d",
                             $time, m_fault, m_fault_cause, m_runaway_phase);
                    bad_fields++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("pwm_out", int'(want.pwm), int'(m_pwm_out));
                    check_field("active", int'(want.active), int'(m_active));
                    check_field("fault", int'(want.fault), int'(m_fault));
                    check_field("fault_cause", int'(want.cause), int'(m_fault_cause));
                    check_field("runaway_phase", int'(want.phase), int'(m_runaway_phase));
                end
            end
            if (s_valid && s_ready) begin
                predict_beat(s_func, int'($signed(s_temperature)));
            end
        end
        mismatches <= bad_fields;
        pending    <= expected_status.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the heater supervisor: a short directed run over the limits and
// corner cases, then random register settings, each followed by a temperature
// trace shaped to settle, stall, run away, overheat, stay cold or go random.
// Sender gaps and receiver stalls are drawn per beat; the checker beside the
// block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;

    import hbbsm_pkg::*;

    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         ITEM_GOAL   = 500;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func          = FUNC_TICK;
    logic [12:0] s_temperature   = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_pwm_out;
    logic        m_active;
    logic        m_fault;
    logic [2:0]  m_fault_cause;
    logic [1:0]  m_runaway_phase;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [4:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   pending;
    int   beats_sent = 0;
    int   hold_cnt   = 0;
    int   quiet      = 0;
    bit   gaps_on    = 1'b1;
    bit   stalls_on  = 1'b1;
    cfg_t setup;

    heater_bang_bang_safety_monitor_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_temperature   (s_temperature),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_out       (m_pwm_out),
        .m_active        (m_active),
        .m_fault         (m_fault),
        .m_fault_cause   (m_fault_cause),
        .m_runaway_phase (m_runaway_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    heater_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_temperature   (s_temperature),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_out       (m_pwm_out),
        .m_active        (m_active),
        .m_fault         (m_fault),
        .m_fault_cause   (m_fault_cause),
        .m_runaway_phase (m_runaway_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic cfg_t pack_setup(int tg, int mx, int mn, int hy, int iv, int pd,
                                        int inc, int md);
        cfg_t c;
        c.set_point      = tg[11:0];
        c.max_temp       = mx[11:0];
        c.min_temp       = mn[12:0];
        c.hysteresis     = hy[7:0];
        c.check_interval = iv[9:0];
        c.rise_window    = pd[9:0];
        c.rise_step      = inc[7:0];
        c.mode_flags     = md[1:0];
        return c;
    endfunction

    function automatic cfg_t random_setup();
        int tg;
        int mx;
        int mn;
        int hy;
        int iv;
        int pd;
        int inc;
        int md;
        mx  = chance(15) ? (chance(50) ? 4095 : pick(0, 15)) : pick(700, 1300);
        tg  = chance(10) ? (chance(50) ? 4095 : 0) : pick(200, 1100);
        mn  = chance(15) ? (chance(50) ? -400 : 4095) : pick(-150, 100);
        hy  = chance(10) ? 255 : pick(0, 16);
        iv  = chance(15) ? (chance(50) ? 0 : 1023) : pick(1, 6);
        pd  = chance(15) ? (chance(50) ? 0 : 1023) : pick(4, 30);
        inc = chance(10) ? 255 : pick(0, 24);
        md  = chance(80) ? (2 * pick(0, 1) + 1) : pick(0, 3);
        return pack_setup(tg, mx, mn, hy, iv, pd, inc, md);
    endfunction

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setup(cfg_t c);
        setup = c;
        reg_write(REG_TARGET, 32'(c.set_point));
        reg_write(REG_MAX, 32'(c.max_temp));
        reg_write(REG_MIN, {{19{c.min_temp[12]}}, c.min_temp});
        reg_write(REG_HYST, 32'(c.hysteresis));
        reg_write(REG_INTERVAL, 32'(c.check_interval));
        reg_write(REG_PERIOD, 32'(c.rise_window));
        reg_write(REG_INCREASE, 32'(c.rise_step));
        reg_write(REG_MODE, 32'(c.mode_flags));
    endtask

    task automatic send_beat(logic [1:0] op, int t);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= op;
        s_temperature <= t[12:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != FUNC_SPARE) begin
            beats_sent++;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic run_episode(int style, int ticks);
        int         temp;
        int         aim;
        int         hy;
        int         k;
        logic [1:0] op;
        aim = int'(setup.set_point);
        if (aim > int'(setup.max_temp) - 10) begin
            aim = int'(setup.max_temp) - 10;
        end
        if (aim < 0) begin
            aim = 0;
        end
        hy   = int'(setup.hysteresis);
        temp = pick(-100, 100);
        if (chance(70)) begin
            send_beat(FUNC_CLEAR, temp);
        end
        send_beat(FUNC_ARM, temp);
        for (k = 0; k < ticks; k++) begin
            case (style)
                0: temp = (temp < aim - hy - 4) ? temp + pick(1, 12)
                                                : aim + pick(-hy - 4, hy + 4);
                1: temp = temp + pick(-1, 1);
                2: temp = (k < ticks / 3)
                          ? ((temp < aim) ? temp + pick(10, 60) : aim + pick(-8, 8))
                          : aim - pick(17, 60);
                3: temp = temp + pick(5, 40);
                4: temp = int'($signed(setup.min_temp)) - pick(1, 20);
                default: temp = pick(-400, 4095);
            endcase
            if (temp < -400) begin
                temp = -400;
            end
            if (temp > 4095) begin
                temp = 4095;
            end
            op = FUNC_TICK;
            if (style == 5) begin
                op = 2'(pick(0, 3));
            end else if (chance(3)) begin
                op = FUNC_SPARE;
            end else if (chance(2)) begin
                op = FUNC_CLEAR;
            end else if (chance(3)) begin
                op = FUNC_ARM;
            end
            send_beat(op, temp);
            if (chance(2)) begin
                wait_idle();
            end
        end
    endtask

    always @(posedge aclk) begin : rx_pace
        int w;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (m_valid && m_ready) begin
            w = stalls_on ? $urandom_range(0, 3) : 0;
            if (w != 0) begin
                m_ready  <= 1'b0;
                hold_cnt <= w - 1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        int style;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: target zero, so arming switches control off
        send_beat(FUNC_TICK, 0);
        send_beat(FUNC_ARM, 0);
        wait_idle();

        // target clamped to max - 10, widest watch rise, decision every tick
        apply_setup(pack_setup(4095, 4095, -400, 0, 0, 1, 255, 1));
        send_beat(FUNC_ARM, -400);
        send_beat(FUNC_TICK, 4095);
        send_beat(FUNC_TICK, -400);
        send_beat(FUNC_TICK, 100);
        send_beat(FUNC_SPARE, 1234);
        send_beat(FUNC_CLEAR, 0);
        wait_idle();

        // cooler, clamped target at zero, then over-temperature and refused arm
        apply_setup(pack_setup(5, 0, 4095, 255, 1023, 0, 0, 3));
        send_beat(FUNC_ARM, 0);
        send_beat(FUNC_TICK, 1);
        send_beat(FUNC_ARM, 0);
        send_beat(FUNC_TICK, -400);
        send_beat(FUNC_CLEAR, 0);
        wait_idle();

        // protection off, zero target
        apply_setup(pack_setup(0, 1100, 20, 8, 1, 20, 8, 0));
        send_beat(FUNC_ARM, 50);
        send_beat(FUNC_TICK, 4095);
        send_beat(FUNC_SPARE, -1);

        while (beats_sent < ITEM_GOAL) begin
            wait_idle();
            apply_setup(random_setup());
            gaps_on   = chance(70);
            stalls_on = chance(70);
            style     = pick(0, 5);
            run_episode(style, (style == 2) ? 100 : pick(30, 70));
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hbbsm_pkg.sv
hdl/hbbsm_regs.sv
hdl/hbbsm_core.sv
hdl/heater_bang_bang_safety_monitor_unit.sv
tb/sv/heater_result_checker.sv
tb/sv/testbench.sv
